@@ design/bdrt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the banded damage region tracker.
// No dependencies; every other design file refers to it by scoped names.
package bdrt_pkg;

    localparam int MAX_BANDS   = 8;
    localparam int MAX_SPANS   = 4;
    localparam int MAX_RESULTS = 32;
    localparam int COORD_W     = 14;
    localparam int BCNT_W      = $clog2(MAX_BANDS + 1);
    localparam int SCNT_W      = $clog2(MAX_SPANS + 1);
    localparam int SIDX_W      = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
    localparam int RES_W       = $clog2(MAX_RESULTS);

    localparam logic OP_EXPOSE = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // One horizontal band: rows [top, bot), spans [sl[k], sr[k]) for k < cnt.
    typedef struct packed {
        logic [COORD_W-1:0]                top;
        logic [COORD_W-1:0]                bot;
        logic [SCNT_W-1:0]                 cnt;
        logic [MAX_SPANS-1:0][COORD_W-1:0] sl;
        logic [MAX_SPANS-1:0][COORD_W-1:0] sr;
    } band_t;

    typedef struct packed {
        logic take_push;
        logic take_next;
        logic set_top;
    } cell_ctl_t;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
    } req_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [COORD_W-1:0] out_w;
        logic [COORD_W-1:0] out_h;
        logic               is_empty;
        logic               overflowed;
        logic               is_last;
    } rsp_t;

endpackage

@@ design/bdrt_cell.sv @@
`timescale 1ns / 1ps
// One band cell of the chain: loads its neighbour, the push beat, or a new top.
// Depends on bdrt_pkg.
module bdrt_cell
(
    input  logic                        clk,
    input  bdrt_pkg::cell_ctl_t         ctl,
    input  bdrt_pkg::band_t             nbr,
    input  bdrt_pkg::band_t             push,
    input  logic [bdrt_pkg::COORD_W-1:0] new_top,
    output bdrt_pkg::band_t             band
);

    bdrt_pkg::band_t band_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.take_push)
        begin
            band_reg <= push;
        end
        else if (ctl.take_next)
        begin
            band_reg <= nbr;
        end
        else if (ctl.set_top)
        begin
            band_reg.top <= new_top;
        end
    end

    assign band = band_reg;

endmodule

@@ design/bdrt_span_merge.sv @@
`timescale 1ns / 1ps
// Merges one x span into a band's sorted span list; flags a span overflow.
// Depends on bdrt_pkg.
module bdrt_span_merge
(
    input  bdrt_pkg::band_t                                     band,
    input  logic [bdrt_pkg::COORD_W-1:0]                        l,
    input  logic [bdrt_pkg::COORD_W-1:0]                        r,
    output logic [bdrt_pkg::SCNT_W-1:0]                         cnt,
    output logic [bdrt_pkg::MAX_SPANS-1:0][bdrt_pkg::COORD_W-1:0] sl,
    output logic [bdrt_pkg::MAX_SPANS-1:0][bdrt_pkg::COORD_W-1:0] sr,
    output logic                                                fail
);

    logic [bdrt_pkg::MAX_SPANS-1:0] lft;
    logic [bdrt_pkg::MAX_SPANS-1:0] rgt;
    logic [bdrt_pkg::MAX_SPANS-1:0] ovl;
    logic [bdrt_pkg::COORD_W-1:0]   ml;
    logic [bdrt_pkg::COORD_W-1:0]   mr;
    logic [bdrt_pkg::SCNT_W:0]      nl;
    logic [bdrt_pkg::SCNT_W:0]      nr;
    logic [bdrt_pkg::SCNT_W:0]      no;
    logic [bdrt_pkg::SCNT_W:0]      n;
    logic [bdrt_pkg::SCNT_W:0]      src;

    always_comb
    begin
        for (int k = 0; k < bdrt_pkg::MAX_SPANS; k++)
        begin
            lft[k] = (k < int'(band.cnt)) && (band.sr[k] < l);
            rgt[k] = (k < int'(band.cnt)) && (band.sl[k] > r);
            ovl[k] = (k < int'(band.cnt)) && !lft[k] && !rgt[k];
        end
        ml = l;
        mr = r;
        for (int k = 0; k < bdrt_pkg::MAX_SPANS; k++)
        begin
            if (ovl[k] && band.sl[k] < ml)
            begin
                ml = band.sl[k];
            end
            if (ovl[k] && band.sr[k] > mr)
            begin
                mr = band.sr[k];
            end
        end
        nl   = (bdrt_pkg::SCNT_W + 1)'($countones(lft));
        nr   = (bdrt_pkg::SCNT_W + 1)'($countones(rgt));
        no   = (bdrt_pkg::SCNT_W + 1)'($countones(ovl));
        n    = nl + nr + 1'b1;
        fail = n > (bdrt_pkg::SCNT_W + 1)'(bdrt_pkg::MAX_SPANS);
        cnt  = n[bdrt_pkg::SCNT_W-1:0];
        src  = '0;
        // lefts stay put, merged span next, rights move up past the absorbed ones
        for (int j = 0; j < bdrt_pkg::MAX_SPANS; j++)
        begin
            sl[j] = '0;
            sr[j] = '0;
            if ((bdrt_pkg::SCNT_W + 1)'(j) < nl)
            begin
                sl[j] = band.sl[j];
                sr[j] = band.sr[j];
            end
            else if ((bdrt_pkg::SCNT_W + 1)'(j) == nl)
            begin
                sl[j] = ml;
                sr[j] = mr;
            end
            else
            begin
                src = (bdrt_pkg::SCNT_W + 1)'(j) + no - 1'b1;
                if (src < (bdrt_pkg::SCNT_W + 1)'(bdrt_pkg::MAX_SPANS))
                begin
                    sl[j] = band.sl[src[bdrt_pkg::SIDX_W-1:0]];
                    sr[j] = band.sr[src[bdrt_pkg::SIDX_W-1:0]];
                end
            end
        end
    end

endmodule

@@ design/banded_damage_region_tracker_unit.sv @@
`timescale 1ns / 1ps
// Banded damage region tracker: chain of band cells, a span merger and a sequencer.
// Expose: accept, then one band step at a time in S_INS, then a merge sweep
//   through S_MLOAD and S_MRG (a collapse skips it).
// Drain: one result beat per cycle while the consumer keeps up; input stalled until done.
// Reset clears band count, overflow flag and control; band cells are not reset.
// Depends on bdrt_pkg, bdrt_cell, bdrt_span_merge.
module banded_damage_region_tracker_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  bdrt_pkg::req_t               req_data,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output bdrt_pkg::rsp_t               rsp_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [bdrt_pkg::COORD_W-1:0] cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_INS, S_MLOAD, S_MRG, S_DRAIN} state_t;

    state_t                        state_reg, state_next;
    logic [bdrt_pkg::COORD_W-1:0]  sw_reg, sw_next;
    logic [bdrt_pkg::COORD_W-1:0]  sh_reg, sh_next;
    logic [bdrt_pkg::BCNT_W-1:0]   count_reg, count_next;
    logic [bdrt_pkg::BCNT_W-1:0]   rem_reg, rem_next;
    logic                          ovf_reg, ovf_next;
    logic [bdrt_pkg::COORD_W-1:0]  l_reg, l_next;
    logic [bdrt_pkg::COORD_W-1:0]  r_reg, r_next;
    logic [bdrt_pkg::COORD_W-1:0]  t_reg, t_next;
    logic [bdrt_pkg::COORD_W-1:0]  btm_reg, btm_next;
    logic [bdrt_pkg::SIDX_W-1:0]   k_reg, k_next;
    logic [bdrt_pkg::RES_W-1:0]    nres_reg, nres_next;
    bdrt_pkg::band_t               acc_reg, acc_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    bdrt_pkg::rsp_t                rsp_reg, rsp_next;

    // chain control
    logic                          pop;
    logic                          push;
    logic                          collapse;
    logic                          set_top;
    logic [bdrt_pkg::COORD_W-1:0]  new_top;
    bdrt_pkg::band_t               push_band;
    logic [bdrt_pkg::BCNT_W-1:0]   widx;
    bdrt_pkg::cell_ctl_t           ctl_w [bdrt_pkg::MAX_BANDS];
    bdrt_pkg::band_t               cell_q [bdrt_pkg::MAX_BANDS];
    bdrt_pkg::band_t               head;

    // merged spans of the head band
    logic [bdrt_pkg::SCNT_W-1:0]                         m_cnt;
    logic [bdrt_pkg::MAX_SPANS-1:0][bdrt_pkg::COORD_W-1:0] m_sl;
    logic [bdrt_pkg::MAX_SPANS-1:0][bdrt_pkg::COORD_W-1:0] m_sr;
    logic                                                m_fail;

    // clipping
    logic signed [16:0]            cx_l, cx_r, cy_t, cy_b, lim_w, lim_h;
    logic                          clip_empty;
    logic                          emit;
    logic                          last_span;
    logic                          full;
    logic                          covers;
    logic                          same;

    function automatic bdrt_pkg::band_t make_band(
        input logic [bdrt_pkg::COORD_W-1:0] top,
        input logic [bdrt_pkg::COORD_W-1:0] bot,
        input logic [bdrt_pkg::COORD_W-1:0] l,
        input logic [bdrt_pkg::COORD_W-1:0] r
    );
        bdrt_pkg::band_t b;
        b       = '0;
        b.top   = top;
        b.bot   = bot;
        b.cnt   = bdrt_pkg::SCNT_W'(1);
        b.sl[0] = l;
        b.sr[0] = r;
        return b;
    endfunction

    assign head      = cell_q[0];
    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign full      = (count_reg == bdrt_pkg::BCNT_W'(bdrt_pkg::MAX_BANDS));
    assign emit      = (state_reg == S_DRAIN) && (!rsp_valid_reg || !rsp_stall);
    assign last_span = (bdrt_pkg::SCNT_W'(k_reg) + 1'b1) >= head.cnt;

    bdrt_span_merge u_merge
    (
        .band (head),
        .l    (l_reg),
        .r    (r_reg),
        .cnt  (m_cnt),
        .sl   (m_sl),
        .sr   (m_sr),
        .fail (m_fail)
    );

    // band covers check and same-span compare against the accumulator
    always_comb
    begin
        covers = 1'b0;
        same   = (acc_reg.cnt == head.cnt);
        for (int k = 0; k < bdrt_pkg::MAX_SPANS; k++)
        begin
            if (k < int'(head.cnt) && head.sl[k] <= l_reg && head.sr[k] >= r_reg)
            begin
                covers = 1'b1;
            end
            if (k < int'(head.cnt) &&
                (acc_reg.sl[k] != head.sl[k] || acc_reg.sr[k] != head.sr[k]))
            begin
                same = 1'b0;
            end
        end
    end

    // clip the incoming rectangle to the screen
    always_comb
    begin
        lim_w = $signed({3'b000, sw_reg});
        lim_h = $signed({3'b000, sh_reg});
        cx_l  = req_data.rect_x[15] ? 17'sd0 : $signed({1'b0, req_data.rect_x});
        cy_t  = req_data.rect_y[15] ? 17'sd0 : $signed({1'b0, req_data.rect_y});
        cx_r  = $signed({req_data.rect_x[15], req_data.rect_x}) +
                $signed({req_data.rect_w[15], req_data.rect_w});
        cy_b  = $signed({req_data.rect_y[15], req_data.rect_y}) +
                $signed({req_data.rect_h[15], req_data.rect_h});
        if (cx_r > lim_w)
        begin
            cx_r = lim_w;
        end
        if (cy_b > lim_h)
        begin
            cy_b = lim_h;
        end
        clip_empty = (cx_r <= cx_l) || (cy_b <= cy_t);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        sw_next        = sw_reg;
        sh_next        = sh_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        ovf_next       = ovf_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        t_next         = t_reg;
        btm_next       = btm_reg;
        k_next         = k_reg;
        nres_next      = nres_reg;
        acc_next       = acc_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        pop            = 1'b0;
        push           = 1'b0;
        collapse       = 1'b0;
        set_top        = 1'b0;
        new_top        = head.top;
        push_band      = head;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                bdrt_pkg::REG_SCREEN_WIDTH:  sw_next = cfg_data;
                bdrt_pkg::REG_SCREEN_HEIGHT: sh_next = cfg_data;
                default:                     sw_next = sw_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_data.opcode == bdrt_pkg::OP_DRAIN)
                    begin
                        k_next     = '0;
                        nres_next  = '0;
                        state_next = S_DRAIN;
                    end
                    else if (!clip_empty)
                    begin
                        l_next     = cx_l[bdrt_pkg::COORD_W-1:0];
                        r_next     = cx_r[bdrt_pkg::COORD_W-1:0];
                        t_next     = cy_t[bdrt_pkg::COORD_W-1:0];
                        btm_next   = cy_b[bdrt_pkg::COORD_W-1:0];
                        rem_next   = count_reg;
                        state_next = S_INS;
                    end
                end
            end

            S_INS:
            begin
                if (rem_reg == '0)
                begin
                    // tail band below every held band
                    if (t_reg < btm_reg)
                    begin
                        push      = 1'b1;
                        push_band = make_band(t_reg, btm_reg, l_reg, r_reg);
                        count_next = count_reg + 1'b1;
                        t_next    = btm_reg;
                    end
                    state_next = S_MLOAD;
                    if (t_reg < btm_reg && full)
                    begin
                        collapse = 1'b1;
                    end
                end
                else if (t_reg >= btm_reg || t_reg >= head.bot)
                begin
                    push     = 1'b1;
                    pop      = 1'b1;
                    rem_next = rem_reg - 1'b1;
                end
                else if (t_reg < head.top)
                begin
                    // gap above the head band
                    push      = 1'b1;
                    new_top   = (btm_reg < head.top) ? btm_reg : head.top;
                    push_band = make_band(t_reg, new_top, l_reg, r_reg);
                    count_next = count_reg + 1'b1;
                    t_next    = new_top;
                    collapse  = full;
                end
                else if (t_reg == head.top)
                begin
                    if (btm_reg >= head.bot)
                    begin
                        push         = 1'b1;
                        pop          = 1'b1;
                        push_band.cnt = m_cnt;
                        push_band.sl = m_sl;
                        push_band.sr = m_sr;
                        rem_next     = rem_reg - 1'b1;
                        t_next       = head.bot;
                        collapse     = m_fail;
                    end
                    else if (covers)
                    begin
                        push     = 1'b1;
                        pop      = 1'b1;
                        rem_next = rem_reg - 1'b1;
                        t_next   = btm_reg;
                    end
                    else
                    begin
                        // upper part gains the span, lower part keeps the head
                        push          = 1'b1;
                        set_top       = 1'b1;
                        new_top       = btm_reg;
                        push_band.bot = btm_reg;
                        push_band.cnt = m_cnt;
                        push_band.sl  = m_sl;
                        push_band.sr  = m_sr;
                        count_next    = count_reg + 1'b1;
                        t_next        = btm_reg;
                        collapse      = full || m_fail;
                    end
                end
                else
                begin
                    // rectangle starts inside the head band: split it at t
                    push          = 1'b1;
                    set_top       = 1'b1;
                    new_top       = t_reg;
                    push_band.bot = t_reg;
                    count_next    = count_reg + 1'b1;
                    collapse      = full;
                end

                if (collapse)
                begin
                    pop        = 1'b0;
                    set_top    = 1'b0;
                    push       = 1'b1;
                    push_band  = make_band('0, sh_reg, '0, sw_reg);
                    count_next = bdrt_pkg::BCNT_W'(1);
                    ovf_next   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_MLOAD:
            begin
                acc_next   = head;
                pop        = 1'b1;
                count_next = count_reg - 1'b1;
                rem_next   = count_reg - 1'b1;
                state_next = S_MRG;
            end

            S_MRG:
            begin
                if (rem_reg == '0)
                begin
                    push       = 1'b1;
                    push_band  = acc_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_IDLE;
                end
                else if (acc_reg.bot == head.top && same)
                begin
                    acc_next.bot = head.bot;
                    pop          = 1'b1;
                    count_next   = count_reg - 1'b1;
                    rem_next     = rem_reg - 1'b1;
                end
                else
                begin
                    push      = 1'b1;
                    pop       = 1'b1;
                    push_band = acc_reg;
                    acc_next  = head;
                    rem_next  = rem_reg - 1'b1;
                end
            end

            S_DRAIN:
            begin
                if (emit)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.overflowed = ovf_reg;
                    if (count_reg == '0)
                    begin
                        rsp_next.out_x    = '0;
                        rsp_next.out_y    = '0;
                        rsp_next.out_w    = '0;
                        rsp_next.out_h    = '0;
                        rsp_next.is_empty = 1'b1;
                        rsp_next.is_last  = 1'b1;
                        ovf_next          = 1'b0;
                        state_next        = S_IDLE;
                    end
                    else
                    begin
                        rsp_next.out_x    = head.sl[k_reg];
                        rsp_next.out_y    = head.top;
                        rsp_next.out_w    = head.sr[k_reg] - head.sl[k_reg];
                        rsp_next.out_h    = head.bot - head.top;
                        rsp_next.is_empty = 1'b0;
                        rsp_next.is_last  = (count_reg == bdrt_pkg::BCNT_W'(1) && last_span) ||
                            (nres_reg == bdrt_pkg::RES_W'(bdrt_pkg::MAX_RESULTS - 1));
                        nres_next         = nres_reg + 1'b1;
                        if (rsp_next.is_last)
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                            state_next = S_IDLE;
                        end
                        else if (last_span)
                        begin
                            pop        = 1'b1;
                            count_next = count_reg - 1'b1;
                            k_next     = '0;
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // write slot: tail, or one short when the chain shifts this cycle, or slot 0 on a collapse
    always_comb
    begin
        if (collapse)
        begin
            widx = '0;
        end
        else if (pop)
        begin
            widx = count_reg - 1'b1;
        end
        else
        begin
            widx = count_reg;
        end
        for (int i = 0; i < bdrt_pkg::MAX_BANDS; i++)
        begin
            ctl_w[i].take_push = push && (widx == bdrt_pkg::BCNT_W'(i));
            ctl_w[i].take_next = pop && !ctl_w[i].take_push;
            ctl_w[i].set_top   = (i == 0) && set_top;
        end
    end

    for (genvar i = 0; i < bdrt_pkg::MAX_BANDS; i++)
    begin : g_cell
        bdrt_pkg::band_t nbr;
        if (i < bdrt_pkg::MAX_BANDS - 1)
        begin : g_mid
            assign nbr = cell_q[i+1];
        end
        else
        begin : g_end
            assign nbr = '0;
        end
        bdrt_cell u_cell
        (
            .clk     (clk),
            .ctl     (ctl_w[i]),
            .nbr     (nbr),
            .push    (push_band),
            .new_top (new_top),
            .band    (cell_q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sw_reg        <= '0;
            sh_reg        <= '0;
            count_reg     <= '0;
            rem_reg       <= '0;
            ovf_reg       <= 1'b0;
            l_reg         <= '0;
            r_reg         <= '0;
            t_reg         <= '0;
            btm_reg       <= '0;
            k_reg         <= '0;
            nres_reg      <= '0;
            acc_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sw_reg        <= sw_next;
            sh_reg        <= sh_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            ovf_reg       <= ovf_next;
            l_reg         <= l_next;
            r_reg         <= r_next;
            t_reg         <= t_next;
            btm_reg       <= btm_next;
            k_reg         <= k_next;
            nres_reg      <= nres_next;
            acc_reg       <= acc_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bdrt_pkg::BCNT_W'(bdrt_pkg::MAX_BANDS))
        else $error("band count beyond capacity");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |-> (rem_reg <= count_reg))
        else $error("unvisited bands exceed held bands");

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && rsp_next.is_last) |=> (count_reg == '0 && !ovf_reg && state_reg == S_IDLE))
        else $error("drain did not empty the list");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.is_empty) |-> rsp_data.is_last)
        else $error("empty result not marked last");
`endif

endmodule
